>>> src/hamiltonian_cycle_enumerator_unit_assert.svh
// assertion macros shared by the checker of the hamiltonian cycle enumerator
`ifndef HAMILTONIAN_CYCLE_ENUMERATOR_UNIT_ASSERT_SVH
`define HAMILTONIAN_CYCLE_ENUMERATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define HCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define HCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hce_pkg.sv
// shared types and codes of the hamiltonian cycle enumerator
package hce_pkg;

	localparam int NODE_W = 5;
	localparam int CFG_W  = 5;

	// request codes
	localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
	localparam logic [1:0] REQ_CLEAR    = 2'd1;
	localparam logic [1:0] REQ_RESTART  = 2'd2;
	localparam logic [1:0] REQ_NEXT     = 2'd3;

	// register indexes
	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_ORIGIN     = 1'b1;

	// result status codes
	localparam logic ST_NODE      = 1'b0;
	localparam logic ST_EXHAUSTED = 1'b1;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd2;
	localparam logic [CFG_W-1:0] ORIGIN_RST     = 5'd1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} hce_req_t;

	typedef struct packed {
		logic              status;
		logic [NODE_W-1:0] node;
		logic              last;
	} hce_res_t;

	typedef struct packed {
		logic add_edge;
		logic clear_adj;
		logic init;
		logic step;
		logic emit_node;
		logic emit_close;
		logic emit_exh;
	} hce_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic hit;
		logic exhaust;
		logic out_free;
		logic emit_last_pos;
	} hce_stat_t;

endpackage

>>> src/hce_stream_if.sv
// valid/ready stream channel carrying one payload
interface hce_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/hamiltonian_cycle_enumerator_unit.sv
// top level of the hamiltonian cycle enumerator: controller, datapath and channels
// add edge, clear and restart requests are carried out as they are accepted and give no result
// a find request: accept, a setup step in the INIT state on a fresh search, then one
// SEARCH step per candidate node tried or level backed out, up to MAX_NODES tries per level
// one request in flight; a found cycle gives one result per node in use plus a closing origin result, one if exhausted
// reset clears the matrix and search flags at once and sets node count 2, origin node 1
module hamiltonian_cycle_enumerator_unit
	import hce_pkg::*;
#(
	parameter int MAX_NODES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	hce_stream_if.sink       req,
	hce_stream_if.source     res,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// command and status between the state machine and the datapath
	hce_cmd_t  cmd;
	hce_stat_t stat;
	hce_req_t  req_payload;
	hce_res_t  res_payload;

	assign req_payload = req.data;

	// sequencing: request decode, search flags, emission order
	hce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req_payload.req_type),
		.cfg_we    (cfg_we),
		.stat      (stat),
		.req_ready (req.ready),
		.cmd       (cmd)
	);

	// storage, one search step per cycle, and the output register that
	// frees the request side while a result waits
	hce_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req_payload),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res_payload)
	);

	assign res.data = res_payload;

endmodule

>>> src/hce_ctrl.sv
// controller state machine of the hamiltonian cycle enumerator
module hce_ctrl
	import hce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	input  logic       cfg_we,
	input  hce_stat_t  stat,
	output logic       req_ready,
	output hce_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_EMIT   = 3'd3;
	localparam logic [2:0] S_CLOSE  = 3'd4;
	localparam logic [2:0] S_EXH    = 3'd5;

	logic [2:0] state_q, state_d;
	logic       started_q, started_d;
	logic       done_q, done_d;
	logic       accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		done_d    = done_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_ADD_EDGE: begin
							cmd.add_edge = 1'b1;
							started_d    = 1'b0;
							done_d       = 1'b0;
						end
						REQ_CLEAR: begin
							cmd.clear_adj = 1'b1;
							started_d     = 1'b0;
							done_d        = 1'b0;
						end
						REQ_RESTART: begin
							started_d = 1'b0;
							done_d    = 1'b0;
						end
						REQ_NEXT: begin
							priority if (done_q) begin
								state_d = S_EXH;
							end else if (!started_q) begin
								started_d = 1'b1;
								if (stat.start_ok) begin
									state_d = S_INIT;
								end else begin
									done_d  = 1'b1;
									state_d = S_EXH;
								end
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: ;
					endcase
				end
				// register writes restart the search
				if (cfg_we) begin
					started_d = 1'b0;
					done_d    = 1'b0;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_SEARCH;
			end
			S_SEARCH: begin
				cmd.step = 1'b1;
				priority if (stat.hit) begin
					state_d = S_EMIT;
				end else if (stat.exhaust) begin
					done_d  = 1'b1;
					state_d = S_EXH;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_node = 1'b1;
					if (stat.emit_last_pos) state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (stat.out_free) begin
					cmd.emit_close = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_EXH: begin
				if (stat.out_free) begin
					cmd.emit_exh = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			done_q    <= done_d;
		end
	end

endmodule

>>> src/hce_dp.sv
// datapath: adjacency matrix, path stack, candidate search and result register
module hce_dp
	import hce_pkg::*;
#(
	parameter int MAX_NODES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hce_cmd_t         cmd,
	output hce_stat_t        stat,
	input  hce_req_t         req_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             res_valid,
	input  logic             res_ready,
	output hce_res_t         res_data
);

	localparam int AW      = $clog2(MAX_NODES + 1);
	localparam int STACK_D = MAX_NODES + 2;
	localparam int LW      = $clog2(STACK_D);

	logic [CFG_W-1:0]   node_count_q, origin_q;
	logic [MAX_NODES:0] adj_q [0:MAX_NODES];
	logic [AW-1:0]      stack_q [0:STACK_D-1];
	logic [MAX_NODES:0] used_q, row_prev_q, start_row_q;
	logic [LW-1:0]      lvl_q, k_q;
	logic [AW-1:0]      cur_q, prev_q;
	logic               res_valid_q;
	hce_res_t           res_q;

	logic [AW-1:0]      eff_n, start_a, cand, stk_rd, adj_addr, edge_a, edge_b;
	logic [LW-1:0]      stk_addr;
	logic [MAX_NODES:0] adj_rd;
	logic               cur_lt_n, cand_ok, lvl_is_n, edge_ok;

	// node count above the storage acts as the storage size
	assign eff_n   = (int'(node_count_q) > MAX_NODES) ? AW'(MAX_NODES) : AW'(node_count_q);
	assign start_a = AW'(origin_q);
	assign cand    = cur_q + AW'(1);

	assign cur_lt_n = cur_q < eff_n;
	assign cand_ok  = cur_lt_n && row_prev_q[cand] && !used_q[cand];
	assign lvl_is_n = (lvl_q == LW'(eff_n));

	// one read port on the stack: emission position or the level two below
	assign stk_addr = cmd.emit_node ? k_q : (lvl_q - LW'(2));
	assign stk_rd   = stack_q[stk_addr];

	// one read port on the matrix
	always_comb begin
		priority if (cmd.init) adj_addr = start_a;
		else if (cand_ok)      adj_addr = cand;
		else                   adj_addr = stk_rd;
	end
	assign adj_rd = adj_q[adj_addr];

	assign edge_ok = (req_data.node_a != '0) && (int'(req_data.node_a) <= MAX_NODES) &&
		(req_data.node_b != '0) && (int'(req_data.node_b) <= MAX_NODES);
	assign edge_a  = AW'(req_data.node_a);
	assign edge_b  = AW'(req_data.node_b);

	assign stat.start_ok      = (int'(eff_n) >= 2) && (origin_q != '0) &&
		(int'(origin_q) <= int'(eff_n));
	assign stat.hit           = cand_ok && lvl_is_n && start_row_q[cand];
	assign stat.exhaust       = !cur_lt_n && (lvl_q == LW'(2));
	assign stat.out_free      = !res_valid_q || res_ready;
	assign stat.emit_last_pos = (k_q == LW'(eff_n));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			origin_q     <= ORIGIN_RST;
			for (int r = 0; r <= MAX_NODES; r++) adj_q[r] <= '0;
			used_q       <= '0;
			lvl_q        <= LW'(2);
			k_q          <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NODE_COUNT: node_count_q <= cfg_data;
					CFG_ORIGIN:     origin_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear_adj) begin
				for (int r = 0; r <= MAX_NODES; r++) adj_q[r] <= '0;
			end else if (cmd.add_edge && edge_ok) begin
				adj_q[edge_a][edge_b] <= 1'b1;
				adj_q[edge_b][edge_a] <= 1'b1;
			end
			if (cmd.init) begin
				used_q <= {{MAX_NODES{1'b0}}, 1'b1} << start_a;
				lvl_q  <= LW'(2);
			end else if (cmd.step) begin
				if (cand_ok) begin
					if (stat.hit) begin
						k_q <= LW'(1);
					end else begin
						used_q[cand] <= 1'b1;
						lvl_q        <= lvl_q + LW'(1);
					end
				end else if (!cur_lt_n) begin
					// backtrack one level
					used_q[prev_q] <= 1'b0;
					lvl_q          <= lvl_q - LW'(1);
				end
			end
			if (cmd.emit_node) k_q <= k_q + LW'(1);
			if (cmd.emit_node || cmd.emit_close || cmd.emit_exh) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// search payload and result register
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			stack_q[1]  <= start_a;
			cur_q       <= '0;
			prev_q      <= start_a;
			row_prev_q  <= adj_rd;
			start_row_q <= adj_rd;
		end else if (cmd.step) begin
			if (cand_ok) begin
				stack_q[lvl_q] <= cand;
				if (stat.hit) begin
					cur_q <= cand;
				end else begin
					cur_q      <= '0;
					prev_q     <= cand;
					row_prev_q <= adj_rd;
				end
			end else if (!cur_lt_n) begin
				cur_q      <= prev_q;
				prev_q     <= stk_rd;
				row_prev_q <= adj_rd;
			end else begin
				cur_q <= cand;
			end
		end
		priority if (cmd.emit_node) begin
			res_q <= '{status: ST_NODE, node: NODE_W'(stk_rd), last: 1'b0};
		end else if (cmd.emit_close) begin
			res_q <= '{status: ST_NODE, node: origin_q, last: 1'b1};
		end else if (cmd.emit_exh) begin
			res_q <= '{status: ST_EXHAUSTED, node: '0, last: 1'b1};
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> src/hce_checker.sv
// port-level checker of the hamiltonian cycle enumerator and its bind
`include "hamiltonian_cycle_enumerator_unit_assert.svh"

module hce_checker
	import hce_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     res_valid,
	input logic     res_ready,
	input hce_res_t res_data
);

	// a waiting result is not withdrawn
	`HCE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// exhausted status is a run of its own with node zero
	`HCE_ASSERT_NOW(a_exh_form, res_valid && (res_data.status == ST_EXHAUSTED),
		(res_data.node == '0) && res_data.last, "malformed exhausted result")

	// no new request is taken in the middle of a cycle run
	`HCE_ASSERT_NOW(a_no_req_mid_run, res_valid && !res_data.last, !(req_valid && req_ready),
		"request taken during a cycle run")

	// a cycle run never breaks into an exhausted status
	`HCE_ASSERT_NEXT(a_run_continues, res_valid && res_ready && !res_data.last,
		!(res_valid && (res_data.status == ST_EXHAUSTED)), "cycle run cut by exhausted status")

endmodule

bind hamiltonian_cycle_enumerator_unit hce_checker u_hce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
